### sv/gsps_pkg.sv
package gsps_pkg;

    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_CELL_SIZE   = 16;
    localparam int DEF_SCALE_SHIFT = 8;

    // grid count width, holds up to 511
    localparam int GRID_W = 9;

    localparam logic [6:0] GRID_RESET = 7'd64;

    // register indexes on the config port
    localparam logic [1:0] REG_ORIGIN_LEFT = 2'd0;
    localparam logic [1:0] REG_ORIGIN_TOP  = 2'd1;
    localparam logic [1:0] REG_GRID_COLS   = 2'd2;
    localparam logic [1:0] REG_GRID_ROWS   = 2'd3;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    localparam logic [1:0] OUT_FREE    = 2'd0;
    localparam logic [1:0] OUT_MOVED   = 2'd1;
    localparam logic [1:0] OUT_NOFIT   = 2'd2;
    localparam logic [1:0] OUT_CLEARED = 2'd3;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } gsps_mem_ctl_t;

endpackage

### sv/gsps_grid_mem.sv
module gsps_grid_mem #(
    parameter int ROWS = gsps_pkg::DEF_MAX_ROWS,
    parameter int COLS = gsps_pkg::DEF_MAX_COLS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gsps_pkg::gsps_mem_ctl_t   ctl,
    input  logic [$clog2(ROWS)-1:0]   addr,
    input  logic [COLS-1:0]           wdata,
    output logic [COLS-1:0]           rdata
);

    localparam int AW = $clog2(ROWS);

    logic [COLS-1:0] mem [ROWS];
    logic [ROWS-1:0] row_valid_reg;
    logic [COLS-1:0] rdata_reg;
    logic            rvalid_reg;

    // row data array, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // one valid bit per row; a row never written since clear reads as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                row_valid_reg <= '0;
            end
            else if (ctl.wr)
            begin
                row_valid_reg[addr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                rvalid_reg <= row_valid_reg[addr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

### sv/gsps_edge_div.sv
module gsps_edge_div #(
    parameter int CELL_SIZE = gsps_pkg::DEF_CELL_SIZE
) (
    input  logic               clk,
    input  logic signed [15:0] pix,
    output logic signed [15:0] quot
);

    // floor(n / C) = (n * M) >> SH for n < 2^16
    localparam int              SH    = 16 + $clog2(CELL_SIZE);
    localparam longint unsigned RECIP = ((64'd1 << SH) + CELL_SIZE - 1) / CELL_SIZE;

    logic [16:0] mag;
    logic [17:0] recip;
    logic [34:0] prod_reg;
    logic        neg_reg;
    logic [15:0] quo;

    assign recip = 18'(RECIP);
    assign mag   = pix[15] ? (17'd0 - {pix[15], pix}) : {1'b0, pix};

    always_ff @(posedge clk)
    begin
        prod_reg <= 35'(mag) * 35'(recip);
        neg_reg  <= pix[15];
    end

    // truncate toward zero: divide magnitude, restore sign
    assign quo  = 16'(prod_reg >> SH);
    assign quot = neg_reg ? $signed(16'd0 - quo) : $signed(quo);

endmodule

### sv/grid_sprite_placement_search_core.sv
// Channel  | Signals                                        | Dir
// ---------+------------------------------------------------+-----
// in       | in_valid, in_ready, opcode, want_h/v, anchor,  | in
//          | sprite_width/height, scale                     |
// out      | out_valid, out_ready, place_h, place_v, outcome| out
// cfg      | cfg_write, cfg_index, cfg_data                 | in
//
// One word at a time. A clear goes from idle straight to the done state. A place
// first scales anchor and size (one shared multiplier), then for each candidate
// works out its cell box through the reciprocal divider and checks its bounds,
// then reads and compares each grid row from the single-port occupancy memory;
// marking reads, then writes back, each row. After the wanted
// point up to 4*(cols^2-1) ring candidates are tried.
// Reset (async, active low) empties the grid at once through per-row valid
// bits. A finished word waits in the output register; the next input word is
// taken meanwhile, and a later result holds until that register frees.
module grid_sprite_placement_search_core #(
    parameter int MAX_COLS    = gsps_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = gsps_pkg::DEF_MAX_ROWS,
    parameter int CELL_SIZE   = gsps_pkg::DEF_CELL_SIZE,
    parameter int SCALE_SHIFT = gsps_pkg::DEF_SCALE_SHIFT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [15:0] want_h,
    input  logic signed [15:0] want_v,
    input  logic signed [15:0] anchor_h,
    input  logic signed [15:0] anchor_v,
    input  logic [11:0]        sprite_width,
    input  logic [11:0]        sprite_height,
    input  logic [15:0]        scale,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] place_h,
    output logic signed [15:0] place_v,
    output logic [1:0]         outcome
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int GW = gsps_pkg::GRID_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_EDGE, S_CHECK, S_RD, S_CMP, S_MRD, S_MWR, S_DONE
    } state_t;

    // what the current box belongs to
    typedef enum logic [1:0] {
        PH_WANT, PH_RING, PH_MARKWANT
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    // configuration
    logic signed [15:0] origin_left_reg, origin_top_reg;
    logic [6:0]         grid_cols_reg, grid_rows_reg;
    logic [GW-1:0]      eff_cols, eff_rows;

    // request
    logic signed [15:0] want_h_reg, want_v_reg, anchor_h_reg, anchor_v_reg;
    logic [11:0]        width_reg, height_reg;
    logic [15:0]        scale_reg;
    logic signed [15:0] s_ah_reg, s_w_reg, s_av_reg, s_h_reg;

    // search position
    logic [GW-1:0]       ring_reg;
    logic signed [GW:0]  i_reg;
    logic [1:0]          k_reg;
    logic [2:0]          cnt_reg;
    logic signed [15:0]  cell_l_reg, cell_r_reg, cell_t_reg, cell_b_reg;
    logic signed [15:0]  y_reg;

    logic signed [15:0] res_h_reg, res_v_reg;
    logic [1:0]         res_out_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_h_reg, out_v_reg;
    logic [1:0]         out_code_reg;

    // memory side
    gsps_pkg::gsps_mem_ctl_t mem_ctl;
    logic [MAX_COLS-1:0]     row_rdata, row_mask;

    logic in_acc;
    assign in_acc   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign eff_cols = (GW'(grid_cols_reg) > GW'(MAX_COLS)) ? GW'(MAX_COLS)
                                                           : GW'(grid_cols_reg);
    assign eff_rows = (GW'(grid_rows_reg) > GW'(MAX_ROWS)) ? GW'(MAX_ROWS)
                                                           : GW'(grid_rows_reg);

    // scaling: one 17x17 signed multiply per cycle, floor by arithmetic shift
    logic signed [16:0] sc_op;
    logic signed [33:0] sc_prod;
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sc_op = {anchor_h_reg[15], anchor_h_reg};
            2'd1:    sc_op = $signed({5'd0, width_reg});
            2'd2:    sc_op = {anchor_v_reg[15], anchor_v_reg};
            2'd3:    sc_op = $signed({5'd0, height_reg});
            default: sc_op = '0;
        endcase
    end
    assign sc_prod = sc_op * $signed({1'b0, scale_reg});

    // candidate anchor point for the current ring position
    logic signed [15:0] dd, ee, cand_h, cand_v, rh, rv;
    assign dd = 16'(int'(ring_reg) * CELL_SIZE);
    assign ee = 16'(int'(i_reg) * CELL_SIZE);
    always_comb
    begin
        case (k_reg)
            2'd0:    begin rh = want_h_reg - dd; rv = want_v_reg + ee; end
            2'd1:    begin rh = want_h_reg + dd; rv = want_v_reg + ee; end
            2'd2:    begin rh = want_h_reg + ee; rv = want_v_reg - dd; end
            2'd3:    begin rh = want_h_reg + ee; rv = want_v_reg + dd; end
            default: begin rh = want_h_reg;      rv = want_v_reg;      end
        endcase
    end
    assign cand_h = (phase_reg == PH_RING) ? rh : want_h_reg;
    assign cand_v = (phase_reg == PH_RING) ? rv : want_v_reg;

    // pixel edges relative to the map origin, all with 16-bit wrap
    logic signed [15:0] px_l, px_r, px_t, px_b, edge_px, edge_cell;
    assign px_l = cand_h - s_ah_reg;
    assign px_r = px_l + s_w_reg;
    assign px_t = cand_v - s_av_reg;
    assign px_b = px_t + s_h_reg;
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    edge_px = px_l - origin_left_reg;
            2'd1:    edge_px = px_r - origin_left_reg;
            2'd2:    edge_px = px_t - origin_top_reg;
            2'd3:    edge_px = px_b - origin_top_reg;
            default: edge_px = '0;
        endcase
    end

    gsps_edge_div #(.CELL_SIZE(CELL_SIZE)) u_div (
        .clk  (clk),
        .pix  (edge_px),
        .quot (edge_cell)
    );

    // box tests
    logic in_bounds, box_empty, row_hit, last_row;
    assign in_bounds = (cell_l_reg >= 16'sd1) && (cell_t_reg >= 16'sd1)
                    && (cell_r_reg < $signed(16'(eff_cols)))
                    && (cell_b_reg < $signed(16'(eff_rows)));
    assign box_empty = (cell_r_reg < cell_l_reg) || (cell_b_reg < cell_t_reg);
    assign row_hit   = |(row_rdata & row_mask);
    assign last_row  = (y_reg == cell_b_reg);

    always_comb
    begin
        for (int x = 0; x < MAX_COLS; x++)
        begin
            row_mask[x] = (int'(cell_l_reg) <= x) && (x <= int'(cell_r_reg));
        end
    end

    // ring stepping
    logic more_ring;
    assign more_ring = ((GW+1)'(ring_reg) + 1'b1) < (GW+1)'(eff_cols);

    always_comb
    begin
        mem_ctl.clr = in_acc && (opcode == gsps_pkg::OP_CLEAR);
        mem_ctl.rd  = (state_reg == S_RD) || (state_reg == S_MRD);
        mem_ctl.wr  = (state_reg == S_MWR);
    end

    gsps_grid_mem #(.ROWS(MAX_ROWS), .COLS(MAX_COLS)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .addr  (y_reg[AW-1:0]),
        .wdata (row_rdata | row_mask),
        .rdata (row_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_left_reg <= '0;
            origin_top_reg  <= '0;
            grid_cols_reg   <= gsps_pkg::GRID_RESET;
            grid_rows_reg   <= gsps_pkg::GRID_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gsps_pkg::REG_ORIGIN_LEFT: origin_left_reg <= $signed(cfg_data);
                gsps_pkg::REG_ORIGIN_TOP:  origin_top_reg  <= $signed(cfg_data);
                gsps_pkg::REG_GRID_COLS:   grid_cols_reg   <= cfg_data[6:0];
                gsps_pkg::REG_GRID_ROWS:   grid_rows_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // request payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            want_h_reg   <= want_h;
            want_v_reg   <= want_v;
            anchor_h_reg <= anchor_h;
            anchor_v_reg <= anchor_v;
            width_reg    <= sprite_width;
            height_reg   <= sprite_height;
            scale_reg    <= scale;
        end
        if (state_reg == S_SCALE)
        begin
            case (cnt_reg[1:0])
                2'd0:    s_ah_reg <= 16'(sc_prod >>> SCALE_SHIFT);
                2'd1:    s_w_reg  <= 16'(sc_prod >>> SCALE_SHIFT);
                2'd2:    s_av_reg <= 16'(sc_prod >>> SCALE_SHIFT);
                default: s_h_reg  <= 16'(sc_prod >>> SCALE_SHIFT);
            endcase
        end
        if (state_reg == S_EDGE)
        begin
            case (cnt_reg)
                3'd1:    cell_l_reg <= edge_cell;
                3'd2:    cell_r_reg <= edge_cell;
                3'd3:    cell_t_reg <= edge_cell;
                3'd4:    cell_b_reg <= edge_cell;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_WANT;
            cnt_reg       <= '0;
            ring_reg      <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            y_reg         <= '0;
            res_h_reg     <= '0;
            res_v_reg     <= '0;
            res_out_reg   <= gsps_pkg::OUT_FREE;
            out_valid_reg <= 1'b0;
            out_h_reg     <= '0;
            out_v_reg     <= '0;
            out_code_reg  <= gsps_pkg::OUT_FREE;
        end
        else
        begin
            // drained result word; a reload in S_DONE takes precedence
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        cnt_reg <= '0;
                        if (opcode == gsps_pkg::OP_CLEAR)
                        begin
                            res_h_reg   <= '0;
                            res_v_reg   <= '0;
                            res_out_reg <= gsps_pkg::OUT_CLEARED;
                            state_reg   <= S_DONE;
                        end
                        else
                        begin
                            phase_reg <= PH_WANT;
                            state_reg <= S_SCALE;
                        end
                    end
                end

                S_SCALE:
                begin
                    if (cnt_reg == 3'd3)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_EDGE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end

                S_EDGE:
                begin
                    if (cnt_reg == 3'd4)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end

                S_CHECK, S_CMP:
                begin
                    if (phase_reg == PH_MARKWANT)
                    begin
                        // no fit: mark the wanted box if it lies in bounds and is not empty
                        y_reg     <= cell_t_reg;
                        state_reg <= (in_bounds && !box_empty) ? S_MRD : S_DONE;
                    end
                    else if ((state_reg == S_CHECK && !in_bounds)
                          || (state_reg == S_CMP && row_hit))
                    begin
                        // candidate fails: step to the next one
                        state_reg <= S_EDGE;
                        if (phase_reg == PH_WANT)
                        begin
                            if (eff_cols > GW'(1))
                            begin
                                phase_reg <= PH_RING;
                                ring_reg  <= GW'(1);
                                i_reg     <= -(GW+1)'(1);
                                k_reg     <= '0;
                            end
                            else
                            begin
                                phase_reg <= PH_MARKWANT;
                            end
                        end
                        else if (k_reg != 2'd3)
                        begin
                            k_reg <= k_reg + 2'd1;
                        end
                        else
                        begin
                            k_reg <= '0;
                            if (i_reg < $signed({1'b0, ring_reg}))
                            begin
                                i_reg <= i_reg + $signed((GW+1)'(1));
                            end
                            else if (more_ring)
                            begin
                                ring_reg <= ring_reg + 1'b1;
                                i_reg    <= -$signed({1'b0, ring_reg + 1'b1});
                            end
                            else
                            begin
                                phase_reg <= PH_MARKWANT;
                            end
                        end
                        if (phase_reg == PH_RING && k_reg == 2'd3
                            && !(i_reg < $signed({1'b0, ring_reg})) && !more_ring)
                        begin
                            res_h_reg   <= want_h_reg;
                            res_v_reg   <= want_v_reg;
                            res_out_reg <= gsps_pkg::OUT_NOFIT;
                        end
                        if (phase_reg == PH_WANT && !(eff_cols > GW'(1)))
                        begin
                            res_h_reg   <= want_h_reg;
                            res_v_reg   <= want_v_reg;
                            res_out_reg <= gsps_pkg::OUT_NOFIT;
                        end
                    end
                    else if (state_reg == S_CHECK && !box_empty)
                    begin
                        y_reg     <= cell_t_reg;
                        state_reg <= S_RD;
                    end
                    else if (state_reg == S_CMP && !last_row)
                    begin
                        y_reg     <= y_reg + 16'sd1;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        // fits: take it and mark its cells
                        res_h_reg   <= cand_h;
                        res_v_reg   <= cand_v;
                        res_out_reg <= (phase_reg == PH_WANT) ? gsps_pkg::OUT_FREE
                                                              : gsps_pkg::OUT_MOVED;
                        y_reg       <= cell_t_reg;
                        state_reg   <= box_empty ? S_DONE : S_MRD;
                    end
                end

                S_RD:
                begin
                    state_reg <= S_CMP;
                end

                S_MRD:
                begin
                    state_reg <= S_MWR;
                end

                S_MWR:
                begin
                    if (last_row)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        y_reg     <= y_reg + 16'sd1;
                        state_reg <= S_MRD;
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_h_reg     <= res_h_reg;
                        out_v_reg     <= res_v_reg;
                        out_code_reg  <= res_out_reg;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign place_h   = out_h_reg;
    assign place_v   = out_v_reg;
    assign outcome   = out_code_reg;

endmodule

### sv/gsps_checker.sv
module gsps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] place_h,
    input logic signed [15:0] place_v,
    input logic [1:0]         outcome
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(place_h)
            && $stable(place_v) && $stable(outcome))
    else $error("result word changed while stalled");

    // a clear reports the point (0, 0)
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome == gsps_pkg::OUT_CLEARED |-> place_h == 16'sd0
            && place_v == 16'sd0)
    else $error("clear result not at zero");

    // one word in flight: input closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

    // a new result only appears from a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
    else $error("result without work");

endmodule

bind grid_sprite_placement_search_core gsps_checker u_gsps_checker (.*);
